// ===== rtl/fastq_quality_stats_accumulator_macros.svh =====
// Assertion macros for the accumulator RTL.
`ifndef FASTQ_QUALITY_STATS_ACCUMULATOR_MACROS_SVH
`define FASTQ_QUALITY_STATS_ACCUMULATOR_MACROS_SVH
// Implication checked every clock, disabled during reset.
`define FQS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset.
`define FQS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/fqs_pkg.sv =====
// Shared types and constants for the quality statistics accumulator.
package fqs_pkg;
  localparam int unsigned MaxLen = 65536;
  localparam int unsigned AddrW = $clog2(MaxLen);
  localparam int unsigned PosW = 32;
  localparam int unsigned SumW = 40;
  localparam logic [7:0] MaxThresh = 8'd74;
  localparam logic [7:0] MinThresh = 8'd58;
  localparam logic [6:0] OffsetHigh = 7'd64;
  localparam logic [6:0] OffsetLow = 7'd33;

  typedef enum logic [2:0] {
    StClear, StIdle, StRead, StWrite, StDiv, StOut
  } state_e;

  typedef struct packed {
    logic             start;
    logic [SumW-1:0]  dividend;
    logic [PosW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] quotient;
  } div_rsp_t;
endpackage

// ===== rtl/fqs_table_ram.sv =====
// Synchronous RAM with one write port and one registered read port.
module fqs_table_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== rtl/fqs_avg_div.sv =====
// Restoring divider: read byte sum over read length, saturated to 255.
module fqs_avg_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fqs_pkg::div_req_t req_i,
  output fqs_pkg::div_rsp_t rsp_o
);
  import fqs_pkg::*;

  logic [SumW-1:0]     quo_q, quo_d;
  logic [PosW:0]       rem_q, rem_d;
  logic [PosW-1:0]     den_q, den_d;
  logic [$clog2(SumW+1)-1:0] cnt_q, cnt_d;
  logic                busy_q, busy_d, done_q, done_d;
  logic [PosW:0]       trial;

  always_comb begin
    quo_d = quo_q; rem_d = rem_q; den_d = den_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    trial = '0;
    if (req_i.start) begin
      quo_d = req_i.dividend;
      rem_d = '0;
      den_d = req_i.divisor;
      cnt_d = ($clog2(SumW+1))'(SumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q[PosW-1:0], quo_q[SumW-1]};
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[SumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[SumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == ($clog2(SumW+1))'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quotient = (quo_q[SumW-1:8] != '0) ? 8'hFF : quo_q[7:0];
endmodule

// ===== rtl/fastq_quality_stats_accumulator.sv =====
// Top level: per-position quality statistics and a read-length histogram held in three RAM tables.
// Channel | Direction | Handshake
// in      | input     | in_valid_i / in_ready_o
// out     | output    | out_valid_o / out_ready_i
// A character without last passes through idle, read and write before the next accept.
// A character with last passes through idle, read, write, the divider, result and load.
// A query passes through idle, read, result and load; one RAM read port per table.
// After reset a clearing pass zeroes all 65536 entries of each table; no beats are taken.
// A result in the output register blocks nothing until the next result is ready;
// that one then waits in its staging registers and holds off the input.
module fastq_quality_stats_accumulator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [7:0]  qual_char_i,
  input  logic        last_i,
  input  logic [15:0] query_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] read_length_o,
  output logic [7:0]  read_avg_qual_o,
  output logic [7:0]  min_qual_o,
  output logic [7:0]  max_qual_o,
  output logic [6:0]  phred_offset_o,
  output logic [47:0] total_bases_o,
  output logic [39:0] read_count_o,
  output logic [47:0] avg_sum_o,
  output logic [47:0] pos_qual_sum_o,
  output logic [39:0] pos_count_o,
  output logic [39:0] length_hist_count_o,
  output logic        overflow_o
);
  import fqs_pkg::*;
  `include "fastq_quality_stats_accumulator_macros.svh"

  state_e state_q, state_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic mode_q, last_q;
  logic [7:0] qc_q;
  logic [15:0] qidx_q;
  logic [7:0] min_q, min_d, max_q, max_d;
  logic [PosW-1:0] pos_q, pos_d, len_q, len_d;
  logic [SumW-1:0] rsum_q, rsum_d;
  logic [47:0] bases_q, bases_d, avgt_q, avgt_d;
  logic [39:0] reads_q, reads_d;
  logic ovf_q, ovf_d;
  logic ov_q, ov_d;
  logic [15:0] rlen_q, rlen_d;
  logic [7:0] ravg_q, ravg_d;
  logic [47:0] osum_q, osum_d;
  logic [39:0] ocnt_q, ocnt_d, ohist_q, ohist_d;
  logic pend_q, pend_d;
  logic hist_inr_q, hist_inr_d;
  logic xfer;
  logic [6:0] offset_cur;
  logic [15:0] out_rlen_q;
  logic [7:0] out_ravg_q, out_min_q, out_max_q;
  logic [6:0] out_off_q;
  logic [47:0] out_bases_q, out_avgt_q, out_sum_q;
  logic [39:0] out_reads_q, out_cnt_q, out_hist_q;
  logic out_ovf_q;

  logic we_pos, we_hist;
  logic [AddrW-1:0] pos_waddr, pos_raddr, hist_waddr, hist_raddr;
  logic [47:0] sum_wdata, sum_rdata;
  logic [39:0] cnt_wdata, cnt_rdata, hist_wdata, hist_rdata;
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic accept, pos_inr;
  logic [PosW-1:0] len_new;

  fqs_table_ram #(.Depth(MaxLen), .Width(48)) u_sum (
    .clk_i, .we_i(we_pos), .waddr_i(pos_waddr), .wdata_i(sum_wdata),
    .raddr_i(pos_raddr), .rdata_o(sum_rdata));
  fqs_table_ram #(.Depth(MaxLen), .Width(40)) u_cnt (
    .clk_i, .we_i(we_pos), .waddr_i(pos_waddr), .wdata_i(cnt_wdata),
    .raddr_i(pos_raddr), .rdata_o(cnt_rdata));
  fqs_table_ram #(.Depth(MaxLen), .Width(40)) u_hist (
    .clk_i, .we_i(we_hist), .waddr_i(hist_waddr), .wdata_i(hist_wdata),
    .raddr_i(hist_raddr), .rdata_o(hist_rdata));
  fqs_avg_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  assign in_ready_o = (state_q == StIdle) && !pend_q;
  assign accept = in_valid_i && in_ready_o;
  assign pos_inr = (pos_q < PosW'(MaxLen));
  assign len_new = (pos_q == '1) ? pos_q : pos_q + 1'b1;
  assign pos_raddr = mode_q ? qidx_q[AddrW-1:0] : pos_q[AddrW-1:0];
  assign hist_raddr = mode_q ? qidx_q[AddrW-1:0] : len_q[AddrW-1:0];
  assign offset_cur = (max_q > MaxThresh && min_q > MinThresh) ? OffsetHigh : OffsetLow;

  always_comb begin
    state_d = state_q; clr_d = clr_q;
    min_d = min_q; max_d = max_q; pos_d = pos_q; len_d = len_q;
    rsum_d = rsum_q; bases_d = bases_q; avgt_d = avgt_q;
    reads_d = reads_q; ovf_d = ovf_q; ov_d = ov_q;
    rlen_d = rlen_q; ravg_d = ravg_q; osum_d = osum_q;
    ocnt_d = ocnt_q; ohist_d = ohist_q; pend_d = pend_q;
    hist_inr_d = hist_inr_q;
    we_pos = 1'b0; we_hist = 1'b0;
    pos_waddr = pos_q[AddrW-1:0]; hist_waddr = len_q[AddrW-1:0];
    sum_wdata = sum_rdata + 48'(qc_q);
    cnt_wdata = cnt_rdata + 40'd1;
    hist_wdata = hist_rdata + 40'd1;
    div_req = '0;
    xfer = 1'b0;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    unique case (state_q)
      StClear: begin
        we_pos = 1'b1; we_hist = 1'b1;
        pos_waddr = clr_q; hist_waddr = clr_q;
        sum_wdata = '0; cnt_wdata = '0; hist_wdata = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == '1) state_d = StIdle;
      end
      StIdle: begin
        if (accept) state_d = StRead;
      end
      StRead: begin
        if (mode_q) begin
          state_d = StOut;
        end else begin
          if (qc_q < min_q) min_d = qc_q;
          if (qc_q > max_q) max_d = qc_q;
          bases_d = bases_q + 48'd1;
          rsum_d = rsum_q + SumW'(qc_q);
          len_d = len_new;
          hist_inr_d = (len_new < PosW'(MaxLen));
          if (!pos_inr) ovf_d = 1'b1;
          state_d = StWrite;
        end
      end
      StWrite: begin
        we_pos = pos_inr;
        pos_d = len_q;
        if (last_q) begin
          div_req.start = 1'b1;
          div_req.dividend = rsum_q;
          div_req.divisor = len_q;
          state_d = StDiv;
        end else begin
          state_d = StIdle;
        end
      end
      StDiv: begin
        if (div_rsp.done) begin
          we_hist = hist_inr_q;
          if (!hist_inr_q) ovf_d = 1'b1;
          reads_d = reads_q + 40'd1;
          avgt_d = avgt_q + 48'(div_rsp.quotient);
          ravg_d = div_rsp.quotient;
          rlen_d = (len_q > 32'hFFFF) ? 16'hFFFF : len_q[15:0];
          pos_d = '0; rsum_d = '0;
          pend_d = 1'b1;
          state_d = StOut;
        end
      end
      StOut: begin
        pend_d = 1'b1;
        if (mode_q) begin
          rlen_d = '0; ravg_d = '0;
          osum_d = sum_rdata; ocnt_d = cnt_rdata; ohist_d = hist_rdata;
        end else begin
          osum_d = '0; ocnt_d = '0; ohist_d = '0;
        end
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
    // The staged result moves into the output register once the state has left StOut,
    // as soon as that register is empty or being emptied.
    if (pend_q && (!ov_q || out_ready_i) && state_q != StOut) begin
      xfer = 1'b1;
      ov_d = 1'b1;
      pend_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear; clr_q <= '0;
      min_q <= 8'hFF; max_q <= '0; pos_q <= '0; len_q <= '0;
      rsum_q <= '0; bases_q <= '0; avgt_q <= '0; reads_q <= '0;
      ovf_q <= 1'b0; ov_q <= 1'b0; pend_q <= 1'b0; hist_inr_q <= 1'b0;
    end else begin
      state_q <= state_d; clr_q <= clr_d;
      min_q <= min_d; max_q <= max_d; pos_q <= pos_d; len_q <= len_d;
      rsum_q <= rsum_d; bases_q <= bases_d; avgt_q <= avgt_d; reads_q <= reads_d;
      ovf_q <= ovf_d; ov_q <= ov_d; pend_q <= pend_d; hist_inr_q <= hist_inr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i; qc_q <= qual_char_i; last_q <= last_i;
      qidx_q <= query_index_i;
    end
    rlen_q <= rlen_d; ravg_q <= ravg_d;
    osum_q <= osum_d; ocnt_q <= ocnt_d; ohist_q <= ohist_d;
    if (xfer) begin
      out_rlen_q <= rlen_q; out_ravg_q <= ravg_q;
      out_min_q <= min_q; out_max_q <= max_q; out_off_q <= offset_cur;
      out_bases_q <= bases_q; out_reads_q <= reads_q; out_avgt_q <= avgt_q;
      out_sum_q <= osum_q; out_cnt_q <= ocnt_q; out_hist_q <= ohist_q;
      out_ovf_q <= ovf_q;
    end
  end

  // The output register holds a snapshot, so later beats can proceed while it waits, until the next result is staged.
  assign out_valid_o = ov_q;
  assign read_length_o = out_rlen_q;
  assign read_avg_qual_o = out_ravg_q;
  assign min_qual_o = out_min_q;
  assign max_qual_o = out_max_q;
  assign phred_offset_o = out_off_q;
  assign total_bases_o = out_bases_q;
  assign read_count_o = out_reads_q;
  assign avg_sum_o = out_avgt_q;
  assign pos_qual_sum_o = out_sum_q;
  assign pos_count_o = out_cnt_q;
  assign length_hist_count_o = out_hist_q;
  assign overflow_o = out_ovf_q;

  `FQS_ASSERT_IMP(a_no_accept_clear, state_q == StClear, !in_ready_o, "accept during clear")
  `FQS_ASSERT_IMP(a_no_accept_pend, pend_q, !in_ready_o, "accept while result staged")
  `FQS_ASSERT_NXT(a_read_follows, accept, state_q == StRead, "accepted item not read")
  `FQS_ASSERT_IMP(a_div_in_div, div_rsp.done, state_q == StDiv, "divider done out of place")
endmodule
